FILE: rtl/bfa_pkg.sv
package bfa_pkg;

    // Field widths of the item and result channels
    localparam int START_W = 10;
    localparam int LEN_W   = 11;
    localparam int FREE_W  = 11;
    localparam int HOLE_W  = 10;

    // Saturation limits of the reported counts
    localparam int FREE_MAX = 2047;
    localparam int HOLE_MAX = 1023;

    // Opcodes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RESERVE = 1'b1;

    // Placement policy codes
    localparam logic POLICY_FIRST = 1'b0;
    localparam logic POLICY_BEST  = 1'b1;

    // Register map
    localparam int             PADDR_W         = 3;
    localparam logic [PADDR_W-1:0] ADDR_FIT_POLICY = 3'd0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_MARK,
        ST_RESULT
    } bfa_state_t;

    // Control from the sequencer to the run tracker
    typedef struct packed {
        logic clear;
        logic step;
        logic is_free;
        logic best_fit;
    } bfa_trk_ctrl_t;

endpackage

FILE: rtl/bitmap_fit_allocator.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   opcode, range_start, run_length
// out       output     out_valid / out_ready granted, placed_start, free_blocks, hole_count
// cfg       input      APB write/read        fit_policy at byte address 0
//
// After reset a clearing pass writes the block map, in_ready low.
// A reserve marks its blocks while it scans; a refused allocate writes nothing, and a
// granted allocate marks its run after the scan, one write per block.
// The single-port-read block map memory sets the rate: one block per cycle.
// One item at a time; in_ready is high only in idle. A finished result waits in the
// output register while the next item is already taken.
module bitmap_fit_allocator #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [bfa_pkg::START_W-1:0]   range_start,
    input  logic [bfa_pkg::LEN_W-1:0]     run_length,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          granted,
    output logic [bfa_pkg::START_W-1:0]   placed_start,
    output logic [bfa_pkg::FREE_W-1:0]    free_blocks,
    output logic [bfa_pkg::HOLE_W-1:0]    hole_count,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfa_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import bfa_pkg::*;

    localparam int AW  = $clog2(NUM_BLOCKS);
    localparam int AW1 = $clog2(NUM_BLOCKS + 1);
    // wide enough for start + length and for a block index
    localparam int CW  = (AW1 > 12) ? AW1 : 12;
    // wide enough to saturate either count
    localparam int OW  = (AW1 > FREE_W) ? AW1 : FREE_W;

    // ---------------------------------------------------------------- state
    bfa_state_t      state_reg, state_next;
    logic            fit_policy_reg, fit_policy_next;

    logic [AW-1:0]   clr_idx_reg, clr_idx_next;
    logic [AW1-1:0]  issue_idx_reg, issue_idx_next;
    logic            issue_done_reg, issue_done_next;
    logic            pend_vld_reg, pend_vld_next;
    logic [AW1-1:0]  pend_idx_reg, pend_idx_next;

    logic            op_reg, op_next;
    logic [START_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CW-1:0]   end_reg, end_next;
    logic            start_ok_reg, start_ok_next;

    logic [AW-1:0]   mark_addr_reg, mark_addr_next;
    logic [AW1-1:0]  mark_left_reg, mark_left_next;

    logic            out_valid_reg, out_valid_next;
    logic            granted_reg, granted_next;
    logic [START_W-1:0] placed_reg, placed_next;
    logic [FREE_W-1:0]  free_reg, free_next;
    logic [HOLE_W-1:0]  hole_reg, hole_next;

    // ---------------------------------------------------------------- block map
    // 1 = free. No reset; the clearing pass fills it.
    logic            map_mem [NUM_BLOCKS];
    logic            rdata_reg;
    logic            map_we;
    logic [AW-1:0]   map_waddr;
    logic            map_wdata;
    logic [AW-1:0]   map_raddr;

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        rdata_reg <= map_mem[map_raddr];
    end

    // ---------------------------------------------------------------- run tracker
    bfa_trk_ctrl_t   trk_ctrl;
    logic            trk_found;
    logic [AW-1:0]   trk_best_start;
    logic [AW1-1:0]  trk_best_len;
    logic [AW1-1:0]  trk_free;
    logic [AW1-1:0]  trk_hole;

    bfa_run_tracker #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_trk (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (trk_ctrl),
        .idx        (pend_idx_reg),
        .need       (len_reg),
        .found      (trk_found),
        .best_start (trk_best_start),
        .best_len   (trk_best_len),
        .free_cnt   (trk_free),
        .hole_cnt   (trk_hole)
    );

    // ---------------------------------------------------------------- scan decode
    logic            in_xfer;
    logic            cfg_wr;
    logic            pend_real;     // pending read is a real block, not the end sentinel
    logic            res_hit;       // reserve covers the pending block
    logic            scan_last;
    logic            out_free;
    logic            alloc_ok;
    logic [CW-1:0]   pend_ext;
    logic [CW-1:0]   need_ext;
    logic [AW1-1:0]  need_a;
    logic [AW1-1:0]  free_after;
    logic [AW1-1:0]  hole_after;
    logic [OW-1:0]   free_ext;
    logic [OW-1:0]   hole_ext;
    logic [CW-1:0]   placed_ext;

    assign in_xfer   = in_valid && (state_reg == ST_IDLE);
    assign cfg_wr    = psel && penable && pwrite && (paddr == ADDR_FIT_POLICY);
    assign out_free  = !out_valid_reg || out_ready;

    assign pend_real = (pend_idx_reg != AW1'(NUM_BLOCKS));
    assign pend_ext  = CW'(pend_idx_reg);
    assign res_hit   = (op_reg == OP_RESERVE) && start_ok_reg && pend_real
                       && (pend_ext >= CW'(start_reg)) && (pend_ext < end_reg);
    assign scan_last = pend_vld_reg && !pend_real;

    assign trk_ctrl.clear    = in_xfer;
    assign trk_ctrl.step     = (state_reg == ST_SCAN) && pend_vld_reg;
    assign trk_ctrl.is_free  = pend_real && rdata_reg && !res_hit;
    assign trk_ctrl.best_fit = (fit_policy_reg == POLICY_BEST);

    // ---------------------------------------------------------------- result math
    // An allocate takes the head of one hole: free drops by the length, and the hole
    // vanishes only when it was filled exactly.
    assign alloc_ok   = (op_reg == OP_ALLOC) && trk_found;
    assign need_ext   = CW'(len_reg);
    assign need_a     = need_ext[AW1-1:0];
    assign free_after = alloc_ok ? (trk_free - need_a) : trk_free;
    assign hole_after = trk_hole - AW1'(alloc_ok && (trk_best_len == need_a));
    assign free_ext   = OW'(free_after);
    assign hole_ext   = OW'(hole_after);
    assign placed_ext = (op_reg == OP_ALLOC) ? CW'(trk_best_start) : CW'(start_reg);

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == AW'(NUM_BLOCKS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = alloc_ok ? ST_MARK : ST_RESULT;
            end
            ST_MARK:
            begin
                if (mark_left_reg == AW1'(1))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // ---------------------------------------------------------------- datapath / outputs
    always_comb
    begin
        fit_policy_next = fit_policy_reg;
        clr_idx_next    = clr_idx_reg;
        issue_idx_next  = issue_idx_reg;
        issue_done_next = issue_done_reg;
        pend_vld_next   = 1'b0;
        pend_idx_next   = issue_idx_reg;
        op_next         = op_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        end_next        = end_reg;
        start_ok_next   = start_ok_reg;
        mark_addr_next  = mark_addr_reg;
        mark_left_next  = mark_left_reg;
        out_valid_next  = out_valid_reg;
        granted_next    = granted_reg;
        placed_next     = placed_reg;
        free_next       = free_reg;
        hole_next       = hole_reg;
        map_we          = 1'b0;
        map_waddr       = clr_idx_reg;
        map_wdata       = 1'b1;
        map_raddr       = issue_idx_reg[AW-1:0];

        if (cfg_wr)
        begin
            fit_policy_next = pwdata[0];
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                map_we       = 1'b1;
                map_waddr    = clr_idx_reg;
                map_wdata    = 1'b1;
                clr_idx_next = clr_idx_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next         = opcode;
                    start_next      = range_start;
                    len_next        = run_length;
                    end_next        = CW'(range_start) + CW'(run_length);
                    start_ok_next   = (CW'(range_start) < CW'(NUM_BLOCKS));
                    issue_idx_next  = '0;
                    issue_done_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // one read issued per cycle; index NUM_BLOCKS is the end sentinel
                pend_vld_next   = !issue_done_reg;
                pend_idx_next   = issue_idx_reg;
                issue_done_next = issue_done_reg || (issue_idx_reg == AW1'(NUM_BLOCKS));
                if (issue_idx_reg != AW1'(NUM_BLOCKS))
                begin
                    issue_idx_next = issue_idx_reg + AW1'(1);
                end
                // reserve marks each covered block right after reading it
                if (pend_vld_reg && res_hit)
                begin
                    map_we    = 1'b1;
                    map_waddr = pend_idx_reg[AW-1:0];
                    map_wdata = 1'b0;
                end
            end
            ST_EVAL:
            begin
                mark_addr_next = trk_best_start;
                mark_left_next = need_a;
            end
            ST_MARK:
            begin
                map_we         = 1'b1;
                map_waddr      = mark_addr_reg;
                map_wdata      = 1'b0;
                mark_addr_next = mark_addr_reg + AW'(1);
                mark_left_next = mark_left_reg - AW1'(1);
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (op_reg == OP_ALLOC)
                    begin
                        granted_next = trk_found;
                    end
                    else
                    begin
                        granted_next = start_ok_reg;
                    end
                    placed_next = granted_next ? placed_ext[START_W-1:0] : '0;
                    free_next   = (free_ext > OW'(FREE_MAX)) ? FREE_W'(FREE_MAX)
                                                             : free_ext[FREE_W-1:0];
                    hole_next   = (hole_ext > OW'(HOLE_MAX)) ? HOLE_W'(HOLE_MAX)
                                                             : hole_ext[HOLE_W-1:0];
                end
            end
            default:
            begin
                map_we = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            fit_policy_reg <= POLICY_FIRST;
            clr_idx_reg    <= '0;
            issue_idx_reg  <= '0;
            issue_done_reg <= 1'b0;
            pend_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fit_policy_reg <= fit_policy_next;
            clr_idx_reg    <= clr_idx_next;
            issue_idx_reg  <= issue_idx_next;
            issue_done_reg <= issue_done_next;
            pend_vld_reg   <= pend_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        op_reg        <= op_next;
        start_reg     <= start_next;
        len_reg       <= len_next;
        end_reg       <= end_next;
        start_ok_reg  <= start_ok_next;
        mark_addr_reg <= mark_addr_next;
        mark_left_reg <= mark_left_next;
        granted_reg   <= granted_next;
        placed_reg    <= placed_next;
        free_reg      <= free_next;
        hole_reg      <= hole_next;
    end

    // ---------------------------------------------------------------- ports
    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign granted      = granted_reg;
    assign placed_start = placed_reg;
    assign free_blocks  = free_reg;
    assign hole_count   = hole_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr == ADDR_FIT_POLICY) ? {31'd0, fit_policy_reg} : 32'd0;

endmodule

FILE: rtl/bfa_run_tracker.sv
module bfa_run_tracker #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bfa_pkg::bfa_trk_ctrl_t                ctrl,
    input  logic [$clog2(NUM_BLOCKS+1)-1:0]       idx,
    input  logic [bfa_pkg::LEN_W-1:0]             need,
    output logic                                  found,
    output logic [$clog2(NUM_BLOCKS)-1:0]         best_start,
    output logic [$clog2(NUM_BLOCKS+1)-1:0]       best_len,
    output logic [$clog2(NUM_BLOCKS+1)-1:0]       free_cnt,
    output logic [$clog2(NUM_BLOCKS+1)-1:0]       hole_cnt
);
    import bfa_pkg::*;

    localparam int AW  = $clog2(NUM_BLOCKS);
    localparam int AW1 = $clog2(NUM_BLOCKS + 1);
    localparam int CW  = (AW1 > LEN_W) ? AW1 : LEN_W;

    logic [AW-1:0]  run_start_reg, run_start_next;
    logic [AW1-1:0] run_len_reg, run_len_next;
    logic           found_reg, found_next;
    logic [AW-1:0]  best_start_reg, best_start_next;
    logic [AW1-1:0] best_len_reg, best_len_next;
    logic [AW1-1:0] free_cnt_reg, free_cnt_next;
    logic [AW1-1:0] hole_cnt_reg, hole_cnt_next;
    logic           fits;
    logic           take;

    // A closing run is a candidate if it holds the request
    assign fits = (CW'(run_len_reg) >= CW'(need)) && (need != '0) && (run_len_reg != '0);
    // first-fit keeps the first candidate; best-fit a strictly shorter one
    assign take = fits && (!found_reg || (ctrl.best_fit && (run_len_reg < best_len_reg)));

    always_comb
    begin
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        found_next      = found_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        free_cnt_next   = free_cnt_reg;
        hole_cnt_next   = hole_cnt_reg;
        if (ctrl.clear)
        begin
            run_start_next  = '0;
            run_len_next    = '0;
            found_next      = 1'b0;
            best_start_next = '0;
            best_len_next   = '0;
            free_cnt_next   = '0;
            hole_cnt_next   = '0;
        end
        else if (ctrl.step)
        begin
            if (ctrl.is_free)
            begin
                if (run_len_reg == '0)
                begin
                    run_start_next = idx[AW-1:0];
                end
                run_len_next  = run_len_reg + AW1'(1);
                free_cnt_next = free_cnt_reg + AW1'(1);
            end
            else
            begin
                if (run_len_reg != '0)
                begin
                    hole_cnt_next = hole_cnt_reg + AW1'(1);
                end
                if (take)
                begin
                    found_next      = 1'b1;
                    best_start_next = run_start_reg;
                    best_len_next   = run_len_reg;
                end
                run_len_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            found_reg      <= 1'b0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            free_cnt_reg   <= '0;
            hole_cnt_reg   <= '0;
        end
        else
        begin
            run_start_reg  <= run_start_next;
            run_len_reg    <= run_len_next;
            found_reg      <= found_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            free_cnt_reg   <= free_cnt_next;
            hole_cnt_reg   <= hole_cnt_next;
        end
    end

    assign found      = found_reg;
    assign best_start = best_start_reg;
    assign best_len   = best_len_reg;
    assign free_cnt   = free_cnt_reg;
    assign hole_cnt   = hole_cnt_reg;

endmodule

FILE: rtl/bfa_checker.sv
module bfa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          granted,
    input logic [bfa_pkg::START_W-1:0]   placed_start,
    input logic [bfa_pkg::FREE_W-1:0]    free_blocks,
    input logic [bfa_pkg::HOLE_W-1:0]    hole_count
);
    import bfa_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(placed_start)
                                    && $stable(free_blocks) && $stable(hole_count))
        else $error("result changed while stalled");

    // one item at a time: a transfer closes the input
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still open after transfer");

    a_fail_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> placed_start == '0)
        else $error("failed result with nonzero start");

    a_holes_le_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, hole_count} <= free_blocks)
        else $error("more holes than free blocks");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (free_blocks == '0) == (hole_count == '0))
        else $error("free count and hole count disagree on empty map");

endmodule

bind bitmap_fit_allocator bfa_checker u_bfa_checker (.*);

FILE: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bfa_pkg::*;

    // Map size of the instance; the shadow map below follows it bit for bit.
    localparam int BLOCKS = 1024;
    // Worst case of one request: full scan, then one write per block of the run.
    localparam int DRAIN_CYCLES = 2 * BLOCKS + 64;
    // Byte address of register index 1, which does not exist.
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

    // One expected result transfer.
    typedef struct {
        logic               granted;
        logic [START_W-1:0] placed;
        logic [FREE_W-1:0]  free_cnt;
        logic [HOLE_W-1:0]  holes;
    } outcome_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               opcode;
    logic [START_W-1:0] range_start;
    logic [LEN_W-1:0]   run_length;
    logic               out_valid;
    logic               out_ready;
    logic               granted;
    logic [START_W-1:0] placed_start;
    logic [FREE_W-1:0]  free_blocks;
    logic [HOLE_W-1:0]  hole_count;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Shadow copy of the block state: 1 = free block.
    bit [BLOCKS-1:0] shadow_free;
    logic            shadow_policy;

    // Expected results, oldest first.
    outcome_t expected_outcomes[$];

    int  fail_count;
    bit  no_stall;     // set during the back-to-back phase: both sides draw zero waits
    int  n_alloc_first;
    int  n_alloc_best;
    int  n_reserve;
    int  n_granted;
    int  n_refused;

    bitmap_fit_allocator #(
        .NUM_BLOCKS (BLOCKS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .range_start  (range_start),
        .run_length   (run_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted      (granted),
        .placed_start (placed_start),
        .free_blocks  (free_blocks),
        .hole_count   (hole_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, several times the slowest legal run (the clearing pass
    // included, and every request marking its longest run).
    initial
    begin
        #60ms;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow model of the allocator
    // ------------------------------------------------------------------

    // Hole search. Scans one step past the end so a hole that touches the
    // last block is closed and considered like any other.
    // First-fit returns the lowest hole that is long enough; best-fit keeps
    // the smallest leftover, strict < so the lowest address wins a tie.
    function automatic bit locate_hole(input int need, output int where);
        int run_start;
        int run_len;
        int best_gap;
        int best_start;
        bit found;
        bit is_free;
        run_start  = 0;
        run_len    = 0;
        best_gap   = 0;
        best_start = 0;
        found      = 1'b0;
        where      = 0;
        for (int i = 0; i <= BLOCKS; i++)
        begin
            is_free = (i < BLOCKS) ? shadow_free[i] : 1'b0;
            if (is_free)
            begin
                if (run_len == 0)
                    run_start = i;
                run_len++;
            end
            else
            begin
                if (run_len > 0 && run_len >= need)
                begin
                    if (shadow_policy == POLICY_FIRST)
                    begin
                        where = run_start;
                        return 1'b1;
                    end
                    if (!found || (run_len - need) < best_gap)
                    begin
                        found      = 1'b1;
                        best_gap   = run_len - need;
                        best_start = run_start;
                    end
                end
                run_len = 0;
            end
        end
        where = best_start;
        return found;
    endfunction

    // Clears a range of the shadow map, clipped at the end of memory.
    function automatic void mark_used(input int first, input int count);
        for (int k = first; k < first + count && k < BLOCKS; k++)
            shadow_free[k] = 1'b0;
    endfunction

    // Shortest and longest hole of the shadow map, 0 when memory is full.
    function automatic void hole_extremes(output int shortest, output int longest);
        int run_len;
        shortest = 0;
        longest  = 0;
        run_len  = 0;
        for (int i = 0; i <= BLOCKS; i++)
        begin
            if (i < BLOCKS && shadow_free[i])
                run_len++;
            else if (run_len > 0)
            begin
                if (shortest == 0 || run_len < shortest)
                    shortest = run_len;
                if (run_len > longest)
                    longest = run_len;
                run_len = 0;
            end
        end
    endfunction

    // Applies one accepted request to the shadow state and returns the
    // result the block must produce for it.
    function automatic outcome_t apply_request(input logic op, input int start, input int len);
        outcome_t res;
        int       where;
        int       free_cnt;
        int       holes;
        bit       prev;
        res.granted = 1'b0;
        res.placed  = '0;
        if (op == OP_ALLOC)
        begin
            // zero length never grants; no fitting hole leaves the map alone
            if (len > 0 && locate_hole(len, where))
            begin
                mark_used(where, len);
                res.granted = 1'b1;
                res.placed  = where[START_W-1:0];
            end
        end
        else if (start < BLOCKS)
        begin
            // used blocks stay used, zero length marks nothing; still granted
            mark_used(start, len);
            res.granted = 1'b1;
            res.placed  = start[START_W-1:0];
        end
        free_cnt = 0;
        holes    = 0;
        prev     = 1'b0;
        for (int i = 0; i < BLOCKS; i++)
        begin
            if (shadow_free[i])
            begin
                free_cnt++;
                if (!prev)
                    holes++;
            end
            prev = shadow_free[i];
        end
        if (free_cnt > FREE_MAX)
            free_cnt = FREE_MAX;
        if (holes > HOLE_MAX)
            holes = HOLE_MAX;
        res.free_cnt = free_cnt[FREE_W-1:0];
        res.holes    = holes[HOLE_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void note_mismatch(input string field, input int want, input int got);
        fail_count++;
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    endfunction

    // Every result transfer is compared with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                fail_count++;
                $error("result transfer with nothing outstanding: granted %0d placed_start %0d",
                       granted, placed_start);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (granted !== want.granted)
                    note_mismatch("granted", want.granted, granted);
                if (placed_start !== want.placed)
                    note_mismatch("placed_start", want.placed, placed_start);
                if (free_blocks !== want.free_cnt)
                    note_mismatch("free_blocks", want.free_cnt, free_blocks);
                if (hole_count !== want.holes)
                    note_mismatch("hole_count", want.holes, hole_count);
            end
        end
    end

    // Random wait per transfer, none in the back-to-back phase.
    function automatic int draw_wait();
        return no_stall ? 0 : $urandom_range(19, 0);
    endfunction

    // Result side: hold out_ready low for a random stretch before each transfer.
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Sends one request; valid stays high across back-to-back transfers.
    task automatic send_request(input logic op, input int start, input int len);
        int       gap;
        outcome_t res;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        range_start <= start[START_W-1:0];
        run_length  <= len[LEN_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        // transfer done at this edge: predict with the state as of now
        res = apply_request(op, start, len);
        expected_outcomes.push_back(res);
        if (op == OP_RESERVE)
            n_reserve++;
        else if (shadow_policy == POLICY_BEST)
            n_alloc_best++;
        else
            n_alloc_first++;
        if (res.granted)
            n_granted++;
        else
            n_refused++;
    endtask

    // Stops sending and waits until every expected result has arrived and
    // the block accepts requests again (also covers the clearing pass).
    // Sampled on the falling edge so the checker's pop cannot race it.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (expected_outcomes.size() != 0 || in_ready !== 1'b1)
            @(negedge clk);
        @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic reg_access(input bit wr, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        wait_until_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only index 0 exists; writes elsewhere are dropped
        if (wr && addr == ADDR_FIT_POLICY)
            shadow_policy = wdata[0];
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] wdata);
        logic [31:0] unused;
        reg_access(1'b1, addr, wdata, unused);
    endtask

    task automatic check_policy_readback();
        logic [31:0] rdata;
        reg_access(1'b0, ADDR_FIT_POLICY, 32'd0, rdata);
        if (rdata !== {31'd0, shadow_policy})
            note_mismatch("fit_policy", shadow_policy, rdata);
    endtask

    // Selects the policy with random junk in the unused upper bits.
    task automatic select_policy(input logic policy);
        logic [31:0] word;
        word    = $urandom();
        word[0] = policy;
        reg_write(ADDR_FIT_POLICY, word);
    endtask

    // One random request. Memory is never freed, so sizes stay small and
    // oversize allocations are aimed past the longest hole: they fail
    // without using up the map while still toggling every length bit.
    task automatic random_request();
        int shortest;
        int longest;
        int pick;
        hole_extremes(shortest, longest);
        pick = $urandom_range(99, 0);
        if (pick < 45)
            send_request(OP_ALLOC, $urandom_range(1023, 0), $urandom_range(2, 1));
        else if (pick < 50)
            send_request(OP_ALLOC, $urandom_range(1023, 0), $urandom_range(16, 4));
        else if (pick < 60)
            send_request(OP_ALLOC, $urandom_range(1023, 0), $urandom_range(2047, longest + 1));
        else if (pick < 67)
            // exact fit of the smallest hole, the case best-fit is built for
            send_request(OP_ALLOC, $urandom_range(1023, 0),
                         (shortest > 0 && shortest <= 40) ? shortest : 1);
        else if (pick < 70)
            send_request(OP_ALLOC, $urandom_range(1023, 0), 0);
        else if (pick < 88)
            send_request(OP_RESERVE, $urandom_range(1023, 0), $urandom_range(2, 1));
        else if (pick < 94)
            // near the top, any length: mostly clipped at the end of memory
            send_request(OP_RESERVE, $urandom_range(1023, 1008), $urandom_range(2047, 0));
        else
            send_request(OP_RESERVE, $urandom_range(1023, 0), $urandom_range(16, 0));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset value, dropped write to a missing index, upper data bits ignored.
    task automatic test_register_access();
        check_policy_readback();
        reg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        check_policy_readback();
        reg_write(ADDR_FIT_POLICY, 32'hFFFF_FFFF);
        check_policy_readback();
        reg_write(ADDR_FIT_POLICY, 32'hFFFF_FFFE);
        check_policy_readback();
    endtask

    // First-fit corner cases on a fresh map.
    task automatic test_first_fit_edges();
        select_policy(POLICY_FIRST);
        send_request(OP_ALLOC, 0, 0);              // zero length: refused
        send_request(OP_ALLOC, 1023, 2047);        // far too long: refused
        send_request(OP_ALLOC, 0, 1025);           // one past the map
        send_request(OP_RESERVE, 0, 0);            // empty reserve, still granted
        send_request(OP_ALLOC, 0, 1);              // lands on block 0
        send_request(OP_RESERVE, 1023, 2047);      // clipped to the last block
        send_request(OP_RESERVE, 8, 2);
        send_request(OP_RESERVE, 8, 1);            // all used already
        send_request(OP_RESERVE, 7, 4);            // partly used
        send_request(OP_ALLOC, 0, 10);             // skips the short low hole
        send_request(OP_ALLOC, 0, 6);              // exact fit of the low hole
        send_request(OP_RESERVE, 1000, 1024);      // clipped, hole now ends at 999
        send_request(OP_ALLOC, 0, 1024);           // refused
    endtask

    // Best-fit: exact fits, a tie between equal holes, a hole that
    // outranks the large one at the top.
    task automatic test_best_fit_ties();
        select_policy(POLICY_BEST);
        send_request(OP_RESERVE, 30, 3);
        send_request(OP_RESERVE, 40, 1);
        send_request(OP_ALLOC, 0, 7);              // exact fit at 33, not 21
        send_request(OP_RESERVE, 50, 1);
        send_request(OP_ALLOC, 0, 5);              // two 9-block holes tie: lower one
        send_request(OP_ALLOC, 0, 9);              // exact fit
        send_request(OP_ALLOC, 0, 2047);
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_RESERVE, 0, 2);            // all used
        send_request(OP_ALLOC, 0, 3);              // smallest leftover
    endtask

    // Random traffic under one policy; halfway through the sender holds off
    // until every outstanding result has come back.
    task automatic test_random_traffic(input logic policy, input int count);
        select_policy(policy);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                wait_until_drained();
            random_request();
        end
    endtask

    // Same traffic with no gaps on either side.
    task automatic test_back_to_back();
        no_stall = 1'b1;
        test_random_traffic(POLICY_FIRST, 50);
        test_random_traffic(POLICY_BEST, 50);
        no_stall = 1'b0;
    endtask

    // Takes whole holes until the map is nearly full, then fills the rest
    // with one reserve over the entire memory.
    task automatic test_exhaustion();
        int shortest;
        int longest;
        select_policy(POLICY_FIRST);
        for (int n = 0; n < 30; n++)
        begin
            hole_extremes(shortest, longest);
            if (longest == 0)
                break;
            send_request(OP_ALLOC, 0, longest);
        end
        send_request(OP_RESERVE, 0, 1024);
        send_request(OP_ALLOC, 0, 1);              // nothing left
        send_request(OP_RESERVE, 512, 1);
        send_request(OP_ALLOC, 0, 1024);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        fail_count    = 0;
        no_stall      = 1'b0;
        n_alloc_first = 0;
        n_alloc_best  = 0;
        n_reserve     = 0;
        n_granted     = 0;
        n_refused     = 0;
        shadow_free   = '1;
        shadow_policy = POLICY_FIRST;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        opcode      <= OP_ALLOC;
        range_start <= '0;
        run_length  <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_first_fit_edges();
        test_best_fit_ties();
        test_random_traffic(POLICY_FIRST, 190);
        test_random_traffic(POLICY_BEST, 190);
        test_back_to_back();
        test_exhaustion();

        // let any stray result show up before judging
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d allocations (%0d first-fit, %0d best-fit) and %0d reservations.",
                 n_alloc_first + n_alloc_best, n_alloc_first, n_alloc_best, n_reserve);
        $display("%0d requests granted, %0d refused; register readback and dropped writes checked.",
                 n_granted, n_refused);
        if (fail_count == 0 && expected_outcomes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
